### src/mte_pkg.sv
// Shared types and constants for the MSR and time-stamp executor.
package mte_pkg;

    // Instruction kind carried by each input beat
    typedef enum logic [1:0] {
        ACT_RDTSC = 2'd0,
        ACT_RDMSR = 2'd1,
        ACT_WRMSR = 2'd2,
        ACT_OTHER = 2'd3
    } t_action;

    // Completion status of one instruction
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_MSR   = 2'd1,
        ST_BAD_INSTR = 2'd2
    } t_status;

    // Register targeted by a decoded instruction
    typedef enum logic [2:0] {
        SEL_NONE,
        SEL_TSC,
        SEL_SYSENTER,
        SEL_APIC,
        SEL_ZERO
    } t_msr_sel;

    // Decoded control passed from the decoder to the register file
    typedef struct packed {
        t_msr_sel   sel;
        logic [1:0] sys_idx;
        logic       rd;
        logic       wr;
        t_status    status;
    } t_dec;

    localparam logic [31:0] MSR_TSC        = 32'h0000_0010;
    localparam logic [31:0] MSR_APIC_BASE  = 32'h0000_001b;
    localparam logic [31:0] MSR_SYSENTER   = 32'h0000_0174;
    localparam logic [31:0] MSR_SYSENTER_L = 32'h0000_0176;
    localparam logic [31:0] MSR_ZERO_8B    = 32'h0000_008b;
    localparam logic [31:0] MSR_ZERO_250   = 32'h0000_0250;
    localparam logic [31:0] MSR_ZERO_258   = 32'h0000_0258;
    localparam logic [31:0] MSR_ZERO_259   = 32'h0000_0259;
    localparam logic [31:0] MSR_ZERO_BLK   = 32'h0000_0268;

    localparam int          SYSENTER_COUNT  = 3;
    localparam logic [63:0] APIC_BASE_RESET = 64'h0000_0000_FEE0_0900;

endpackage

### src/mte_decode.sv
// Instruction and MSR index decoder.
module mte_decode (
    input  logic [1:0]  i_action,
    input  logic [31:0] i_msr_index,
    output mte_pkg::t_dec o_dec
);
    import mte_pkg::*;

    t_msr_sel msr_sel;
    logic     is_sys;
    logic     is_zero;

    // Classify the MSR index
    always_comb begin
        is_sys  = (i_msr_index >= MSR_SYSENTER) && (i_msr_index <= MSR_SYSENTER_L);
        is_zero = (i_msr_index == MSR_ZERO_8B) || (i_msr_index == MSR_ZERO_250) ||
                  (i_msr_index == MSR_ZERO_258) || (i_msr_index == MSR_ZERO_259) ||
                  (i_msr_index[31:3] == MSR_ZERO_BLK[31:3]);
        priority if (i_msr_index == MSR_TSC) begin
            msr_sel = SEL_TSC;
        end else if (is_sys) begin
            msr_sel = SEL_SYSENTER;
        end else if (i_msr_index == MSR_APIC_BASE) begin
            msr_sel = SEL_APIC;
        end else if (is_zero) begin
            msr_sel = SEL_ZERO;
        end else begin
            msr_sel = SEL_NONE;
        end
    end

    // Map the instruction onto read, write and status
    always_comb begin
        o_dec.sel     = SEL_NONE;
        o_dec.sys_idx = i_msr_index[1:0];
        o_dec.rd      = 1'b0;
        o_dec.wr      = 1'b0;
        o_dec.status  = ST_OK;
        unique case (t_action'(i_action))
            ACT_RDTSC: begin
                o_dec.sel = SEL_TSC;
                o_dec.rd  = 1'b1;
            end
            ACT_RDMSR: begin
                o_dec.sel = msr_sel;
                if (msr_sel == SEL_NONE) begin
                    o_dec.status = ST_BAD_MSR;
                end else begin
                    o_dec.rd = 1'b1;
                end
            end
            ACT_WRMSR: begin
                if (msr_sel == SEL_NONE || msr_sel == SEL_ZERO) begin
                    o_dec.status = ST_BAD_MSR;
                end else begin
                    o_dec.sel = msr_sel;
                    o_dec.wr  = 1'b1;
                end
            end
            default: begin
                o_dec.status = ST_BAD_INSTR;
            end
        endcase
    end

endmodule

### src/mte_msr_file.sv
// MSR state: TSC offset, SYSENTER registers and APIC base, with read mux.
module mte_msr_file (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mte_pkg::t_dec i_dec,
    input  logic          i_we,
    input  logic [63:0]   i_write_value,
    input  logic [63:0]   i_host_tsc,
    output logic [63:0]   o_read_value
);
    import mte_pkg::*;

    logic [63:0] r_tsc_offset;
    logic [31:0] r_sysenter [SYSENTER_COUNT];
    logic [63:0] r_apic_base;

    logic [63:0] guest_tsc;
    logic [31:0] sys_rd;
    logic [63:0] rd_mux;

    assign guest_tsc = r_tsc_offset + i_host_tsc;

    // Select the SYSENTER register
    always_comb begin
        unique case (i_dec.sys_idx)
            2'd0:    sys_rd = r_sysenter[0];
            2'd1:    sys_rd = r_sysenter[1];
            2'd2:    sys_rd = r_sysenter[2];
            default: sys_rd = '0;
        endcase
    end

    // Select the read value; writes and errors read as zero
    always_comb begin
        unique case (i_dec.sel)
            SEL_TSC:      rd_mux = guest_tsc;
            SEL_SYSENTER: rd_mux = {32'd0, sys_rd};
            SEL_APIC:     rd_mux = r_apic_base;
            default:      rd_mux = '0;
        endcase
        o_read_value = i_dec.rd ? rd_mux : '0;
    end

    // Update the addressed register on a write beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tsc_offset  <= '0;
            r_sysenter[0] <= '0;
            r_sysenter[1] <= '0;
            r_sysenter[2] <= '0;
            r_apic_base   <= APIC_BASE_RESET;
        end else if (i_we && i_dec.wr) begin
            unique case (i_dec.sel)
                SEL_TSC: begin
                    r_tsc_offset <= i_write_value - i_host_tsc;
                end
                SEL_SYSENTER: begin
                    if (i_dec.sys_idx == 2'd0) r_sysenter[0] <= i_write_value[31:0];
                    if (i_dec.sys_idx == 2'd1) r_sysenter[1] <= i_write_value[31:0];
                    if (i_dec.sys_idx == 2'd2) r_sysenter[2] <= i_write_value[31:0];
                end
                SEL_APIC: begin
                    r_apic_base <= i_write_value;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

### src/msr_and_timestamp_executor.sv
// Top level of the MSR and time-stamp executor: input and result registers.
//
// Usage:
//   Input channel (i_valid / o_ready) carries one RDTSC, RDMSR or WRMSR per
//   beat, with the MSR index, EDX:EAX write value, host TSC, EIP and length.
//   Output channel (o_valid / i_ready) returns one result beat per input
//   beat, in order: read value, value-valid flag, next EIP and status.
//   The beat sits first in the input register, then moves to the result
//   register, from which its result is offered.
//   Throughput: one beat per cycle unless the receiver stalls; decode, the
//   64-bit TSC add or subtract and the register access all sit between the
//   input and result registers.
//   MSR writes take effect at the edge that moves the beat into the result
//   register, so the very next beat already sees the new value.
//   Reset clears the TSC offset and SYSENTER registers, loads the APIC base
//   with its usual value and empties both pipeline registers.
//   When the receiver stalls, the result register holds, the input register
//   fills, and o_ready drops until the result beat is taken.
module msr_and_timestamp_executor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_msr_index,
    input  logic [63:0] i_write_value,
    input  logic [63:0] i_host_tsc,
    input  logic [31:0] i_current_eip,
    input  logic [3:0]  i_instruction_length,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_read_value,
    output logic        o_value_valid,
    output logic [31:0] o_next_eip,
    output logic [1:0]  o_status
);
    import mte_pkg::*;

    // Input register
    logic        r_in_valid;
    logic [1:0]  r_in_action;
    logic [31:0] r_in_index;
    logic [63:0] r_in_wval;
    logic [63:0] r_in_htsc;
    logic [31:0] r_in_eip;
    logic [3:0]  r_in_len;

    // Result register
    logic        r_out_valid;
    logic [63:0] r_read_value;
    logic        r_value_valid;
    logic [31:0] r_next_eip;
    t_status     r_status;

    t_dec        dec;
    logic [63:0] rd_value;
    logic        advance;
    logic        out_free;
    logic [31:0] n_next_eip;

    assign out_free = !r_out_valid || i_ready;
    assign advance  = r_in_valid && out_free;
    assign o_ready  = !r_in_valid || advance;

    mte_decode u_decode (
        .i_action    (r_in_action),
        .i_msr_index (r_in_index),
        .o_dec       (dec)
    );

    mte_msr_file u_msr_file (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_dec         (dec),
        .i_we          (advance),
        .i_write_value (r_in_wval),
        .i_host_tsc    (r_in_htsc),
        .o_read_value  (rd_value)
    );

    // Advance EIP only on success
    assign n_next_eip = (dec.status == ST_OK) ? r_in_eip + {28'd0, r_in_len} : r_in_eip;

    // Capture an input beat whenever the input register is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_action <= i_action;
            r_in_index  <= i_msr_index;
            r_in_wval   <= i_write_value;
            r_in_htsc   <= i_host_tsc;
            r_in_eip    <= i_current_eip;
            r_in_len    <= i_instruction_length;
        end
    end

    // Load the result register, hold while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_read_value  <= rd_value;
            r_value_valid <= dec.rd;
            r_next_eip    <= n_next_eip;
            r_status      <= dec.status;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_read_value  = r_read_value;
    assign o_value_valid = r_value_valid;
    assign o_next_eip    = r_next_eip;
    assign o_status      = r_status;

    // An executed beat always lands in the result register
    a_advance_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("executed beat did not reach the result register");

    // A failed instruction never returns a value
    a_error_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ST_OK) |-> (!r_value_valid && r_read_value == 64'd0))
        else $error("error result carries a read value");

    // A blocked input beat stays in the input register
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_eip) && $stable(r_in_index)))
        else $error("blocked input beat was lost");

    // An executed beat without status OK never advances EIP
    a_error_eip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && dec.status != ST_OK) |=> (r_next_eip == $past(r_in_eip)))
        else $error("EIP advanced on error");

endmodule
